### rtl/lcm_int64_euclid_top_defines.svh
// assertion macros used by the checker file
`ifndef LCM_INT64_EUCLID_TOP_DEFINES_SVH
`define LCM_INT64_EUCLID_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcm check failed");

// next-cycle implication, disabled during reset
`define LCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcm check failed");

// next-cycle implication that also holds across reset
`define LCM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lcm check failed");

`endif

### rtl/lcm_pkg.sv
`timescale 1ns / 1ps

package lcm_pkg;

  // operand width used by the arithmetic
  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // most negative pattern and its clamped magnitude
  localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAG_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef logic [DATA_WIDTH-1:0] word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_QUO_GO,
    ST_QUO_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DONE
  } state_t;

  // divider result and status
  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_res_t;

  // multiplier result and status
  typedef struct packed {
    logic  done;
    word_t product;
  } mul_res_t;

  // absolute value with the most negative value clamped
  function automatic word_t clamp_mag(input word_t v);
    word_t m;
    if (v == SIGN_BIT) begin
      m = MAG_MAX;
    end else if (v[DATA_WIDTH-1]) begin
      m = (~v) + word_t'(1);
    end else begin
      m = v;
    end
    return m;
  endfunction

endpackage

### rtl/lcm_if.sv
`timescale 1ns / 1ps

// operand channel
interface lcm_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// result channel
interface lcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] lcm_value;

  modport source (output valid, output lcm_value, input ready);
  modport sink   (input valid, input lcm_value, output ready);
endinterface

### rtl/lcm_int64_euclid_top.sv
`timescale 1ns / 1ps

// Least common multiple of two signed 64-bit integers. Each operand is taken
// as its absolute value (the most negative value reads as the most positive);
// a zero operand gives zero, otherwise the gcd g comes from Euclid's remainder
// loop and the item's result is (|a|/g)*|b|, wrapped to 64 bits two's
// complement with no overflow flag. One item is worked at a time: in_chan.ready
// is high only while the sequencer is idle, and the result register lets the
// next item enter while a result still waits on out_chan. All arithmetic goes
// through one bit-serial restoring divider and one shift-add multiplier, each
// running start, 64 bit steps and done per use. An item with a zero operand
// skips the arithmetic; otherwise the divider runs once per Euclid remainder
// step and once more for |a|/g, and then the multiplier runs once.
module lcm_int64_euclid_top (
  input  logic clk,
  input  logic rst_n,
  lcm_in_if.sink    in_chan,
  lcm_out_if.source out_chan
);

  lcm_pkg::state_t   state_r, state_nxt;
  lcm_pkg::word_t    a_r, b_r, x_r, y_r, res_r;
  lcm_pkg::word_t    out_lcm_r;
  logic              out_valid_r;
  lcm_pkg::word_t    mag_a, mag_b;
  logic              in_acc, out_load, zero_in;
  logic              div_start, mul_start;
  lcm_pkg::word_t    div_dividend;
  lcm_pkg::div_res_t div_res;
  lcm_pkg::mul_res_t mul_res;

  // operand magnitudes from the low word of each field
  always_comb begin
    mag_a   = lcm_pkg::clamp_mag(in_chan.operand_a[lcm_pkg::DATA_WIDTH-1:0]);
    mag_b   = lcm_pkg::clamp_mag(in_chan.operand_b[lcm_pkg::DATA_WIDTH-1:0]);
    zero_in = (mag_a == '0) || (mag_b == '0);
  end

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == lcm_pkg::ST_DONE) && (!out_valid_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = zero_in ? lcm_pkg::ST_DONE : lcm_pkg::ST_GCD_GO;
        end
      end
      lcm_pkg::ST_GCD_GO:   state_nxt = lcm_pkg::ST_GCD_WAIT;
      lcm_pkg::ST_GCD_WAIT: begin
        if (div_res.done) begin
          state_nxt = (div_res.remainder == '0) ? lcm_pkg::ST_QUO_GO : lcm_pkg::ST_GCD_GO;
        end
      end
      lcm_pkg::ST_QUO_GO:   state_nxt = lcm_pkg::ST_QUO_WAIT;
      lcm_pkg::ST_QUO_WAIT: begin
        if (div_res.done) begin
          state_nxt = lcm_pkg::ST_MUL_GO;
        end
      end
      lcm_pkg::ST_MUL_GO:   state_nxt = lcm_pkg::ST_MUL_WAIT;
      lcm_pkg::ST_MUL_WAIT: begin
        if (mul_res.done) begin
          state_nxt = lcm_pkg::ST_DONE;
        end
      end
      lcm_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = lcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    div_dividend  = x_r;
    case (state_r)
      lcm_pkg::ST_IDLE:   in_chan.ready = 1'b1;
      lcm_pkg::ST_GCD_GO: div_start     = 1'b1;
      lcm_pkg::ST_QUO_GO: begin
        div_start    = 1'b1;
        div_dividend = a_r;
      end
      lcm_pkg::ST_MUL_GO: mul_start     = 1'b1;
      default:            in_chan.ready = 1'b0;
    endcase
  end

  // shared units
  lcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (y_r),
    .res      (div_res)
  );

  lcm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (x_r),
    .mplier (b_r),
    .res    (mul_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // euclid working registers and result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r   <= mag_a;
      b_r   <= mag_b;
      x_r   <= mag_a;
      y_r   <= mag_b;
      res_r <= '0;
    end else if (state_r == lcm_pkg::ST_GCD_WAIT && div_res.done &&
                 div_res.remainder != '0) begin
      x_r <= y_r;
      y_r <= div_res.remainder;
    end else if (state_r == lcm_pkg::ST_QUO_WAIT && div_res.done) begin
      x_r <= div_res.quotient;
    end else if (state_r == lcm_pkg::ST_MUL_WAIT && mul_res.done) begin
      res_r <= mul_res.product;
    end
    if (out_load) begin
      out_lcm_r <= res_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.lcm_value = 64'(signed'(out_lcm_r));

endmodule

### rtl/lcm_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module lcm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lcm_pkg::word_t    dividend,
  input  lcm_pkg::word_t    divisor,
  output lcm_pkg::div_res_t res
);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [lcm_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  lcm_pkg::word_t                rem_r, rem_nxt;
  lcm_pkg::word_t                quo_r, quo_nxt;
  lcm_pkg::word_t                dvs_r, dvs_nxt;
  logic [lcm_pkg::DATA_WIDTH:0]  shifted;
  logic [lcm_pkg::DATA_WIDTH:0]  diff;
  logic                          fits;

  // shift in next dividend bit and trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[lcm_pkg::DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = !diff[lcm_pkg::DATA_WIDTH];
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = lcm_pkg::CNT_W'(lcm_pkg::DATA_WIDTH - 1);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? diff[lcm_pkg::DATA_WIDTH-1:0] : shifted[lcm_pkg::DATA_WIDTH-1:0];
      quo_nxt = {quo_r[lcm_pkg::DATA_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - lcm_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

### rtl/lcm_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, low word of product, one bit per cycle
module lcm_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lcm_pkg::word_t    mcand,
  input  lcm_pkg::word_t    mplier,
  output lcm_pkg::mul_res_t res
);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [lcm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  lcm_pkg::word_t            acc_r, acc_nxt;
  lcm_pkg::word_t            mcd_r, mcd_nxt;
  lcm_pkg::word_t            mpl_r, mpl_nxt;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mcd_nxt  = mcd_r;
    mpl_nxt  = mpl_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = lcm_pkg::CNT_W'(lcm_pkg::DATA_WIDTH - 1);
      acc_nxt = '0;
      mcd_nxt = mcand;
      mpl_nxt = mplier;
    end else if (run_r) begin
      // add partial product for the current multiplier bit
      acc_nxt = mpl_r[0] ? (acc_r + mcd_r) : acc_r;
      mcd_nxt = {mcd_r[lcm_pkg::DATA_WIDTH-2:0], 1'b0};
      mpl_nxt = {1'b0, mpl_r[lcm_pkg::DATA_WIDTH-1:1]};
      cnt_nxt = cnt_r - lcm_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mcd_r <= mcd_nxt;
    mpl_r <= mpl_nxt;
  end

  assign res.done    = done_r;
  assign res.product = acc_r;

endmodule

### rtl/lcm_checker.sv
`timescale 1ns / 1ps
`include "lcm_int64_euclid_top_defines.svh"

// port-level checks on the lcm block
module lcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_lcm_value
);

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result keeps its value
  `LCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_lcm_value))

  // one item at a time: after an item enters the block is busy
  `LCM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, !in_ready)

  // items are never taken on two consecutive edges
  `LCM_ASSERT_NOW(a_no_passthru, clk, rst_n, in_take && $past(in_take), 1'b0)

  // reset leaves no result pending
  `LCM_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n, !out_valid)

endmodule

bind lcm_int64_euclid_top lcm_checker u_lcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_lcm_value (out_chan.lcm_value)
);

### tb/tb_lcm_int64_euclid_top.sv
`timescale 1ns / 1ps

module tb_lcm_int64_euclid_top;

  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FIB_91  = 64'd4660046610375530309;
  localparam logic [63:0] FIB_92  = 64'd7540113804746346429;

  // one item in flight: operands kept for the mismatch report
  typedef struct {
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] lcm;
  } lcm_case_t;

  logic clk;
  logic rst_n;

  lcm_in_if  in_chan ();
  lcm_out_if out_chan ();

  lcm_case_t lcm_pending[$];
  int        error_count = 0;
  bit        idle_on     = 1'b1;

  lcm_int64_euclid_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // magnitude of a two's complement word, most negative reads as most positive
  function automatic lcm_pkg::word_t abs_clamped(input lcm_pkg::word_t v);
    lcm_pkg::word_t most_neg;
    most_neg = lcm_pkg::word_t'(1) << (lcm_pkg::DATA_WIDTH - 1);
    if (v == most_neg) begin
      return most_neg - lcm_pkg::word_t'(1);
    end else if (v[lcm_pkg::DATA_WIDTH-1]) begin
      return -v;
    end
    return v;
  endfunction

  // expected lcm, low DATA_WIDTH bits sign-extended to 64
  function automatic logic [63:0] lcm_of(input logic [63:0] a_raw, input logic [63:0] b_raw);
    lcm_pkg::word_t mag_a;
    lcm_pkg::word_t mag_b;
    lcm_pkg::word_t x;
    lcm_pkg::word_t y;
    lcm_pkg::word_t rem;
    lcm_pkg::word_t prod;
    mag_a = abs_clamped(a_raw[lcm_pkg::DATA_WIDTH-1:0]);
    mag_b = abs_clamped(b_raw[lcm_pkg::DATA_WIDTH-1:0]);
    if (mag_a == '0 || mag_b == '0) begin
      return 64'd0;
    end
    x = mag_a;
    y = mag_b;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    prod = (mag_a / x) * mag_b;
    return 64'($signed(prod));
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_sign(input logic [63:0] v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // send one operand pair and record its expected lcm at acceptance
  task automatic send_operands(input logic [63:0] a, input logic [63:0] b);
    int unsigned gap;
    lcm_case_t   c;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operand_a <= a;
    in_chan.operand_b <= b;
    do @(posedge clk); while (!in_chan.ready);
    c.op_a = a;
    c.op_b = b;
    c.lcm  = lcm_of(a, b);
    lcm_pending.push_back(c);
  endtask

  // result side: random stalls, each item checked against the oldest expectation
  initial begin : result_check
    int unsigned stall;
    lcm_case_t   c;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if (lcm_pending.size() == 0) begin
        $display("%0t: unexpected lcm item: expected none, got %0d",
                 $time, $signed(out_chan.lcm_value));
        error_count++;
      end else begin
        c = lcm_pending.pop_front();
        if (out_chan.lcm_value !== c.lcm) begin
          $display("%0t: lcm(%0d, %0d): expected %0d, got %0d", $time,
                   $signed(c.op_a), $signed(c.op_b), $signed(c.lcm),
                   $signed(out_chan.lcm_value));
          error_count++;
        end
      end
    end
  end

  // extremes, signs, clamp, wrap and the longest euclid chain
  task automatic test_directed();
    send_operands(64'd0, 64'd0);
    send_operands(64'd0, I64_MIN);
    send_operands(I64_MAX, 64'd0);
    send_operands(64'd1, 64'd1);
    send_operands(-64'd1, -64'd1);
    send_operands(I64_MIN, I64_MIN);
    send_operands(I64_MIN, 64'd1);
    send_operands(I64_MIN, -64'd1);
    send_operands(I64_MIN, 64'd2);
    send_operands(I64_MIN, I64_MAX);
    send_operands(I64_MAX, I64_MAX - 64'd1);
    send_operands(64'd12, 64'd18);
    send_operands(-64'd12, 64'd18);
    send_operands(64'd12, -64'd18);
    send_operands(-64'd12, -64'd18);
    send_operands(64'd6, -64'd6);
    send_operands(64'd1, I64_MAX);
    send_operands(FIB_91, FIB_92);
    send_operands(-FIB_92, FIB_91);
    send_operands(64'd4294967291, 64'd4294967279);
    send_operands(64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF);
    send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // one operand zero, the other anything
  task automatic test_zero_operand();
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 1)) send_operands(64'd0, rand_word());
      else send_operands(rand_word(), 64'd0);
    end
  endtask

  // small magnitudes with random signs, short euclid chains
  task automatic test_small_values();
    logic [63:0] a;
    logic [63:0] b;
    for (int i = 0; i < 240; i++) begin
      a = rand_sign(64'($urandom_range(1, 65535)));
      b = rand_sign(64'($urandom_range(1, 65535)));
      send_operands(a, b);
    end
  endtask

  // large operands sharing a common factor
  task automatic test_common_factor();
    logic [63:0] f;
    logic [63:0] a;
    logic [63:0] b;
    for (int i = 0; i < 120; i++) begin
      if ($urandom_range(0, 1)) f = 64'($urandom_range(1, 32'h7FFF_FFFF));
      else f = {16'd0, 16'($urandom_range(0, 65535)), $urandom} | 64'd1;
      a = rand_sign(f * 64'($urandom_range(1, 1000)));
      b = rand_sign(f * 64'($urandom_range(1, 1000)));
      send_operands(a, b);
    end
  endtask

  // full-width random operands, mostly wrapping products
  task automatic test_full_range();
    for (int i = 0; i < 100; i++) begin
      send_operands(rand_word(), rand_word());
    end
  endtask

  // no idling on either side, mixed sizes back to back
  task automatic test_back_to_back();
    logic [63:0] a;
    logic [63:0] b;
    idle_on = 1'b0;
    for (int i = 0; i < 60; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          a = 64'd0;
          b = rand_word();
        end
        1: begin
          a = rand_word();
          b = rand_word();
        end
        default: begin
          a = rand_sign(64'($urandom_range(1, 4095)));
          b = rand_sign(64'($urandom_range(1, 4095)));
        end
      endcase
      send_operands(a, b);
    end
    idle_on = 1'b1;
  endtask

  // main sequence
  initial begin : run_tests
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.operand_a <= '0;
    in_chan.operand_b <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_operand();
    test_small_values();
    test_common_factor();
    test_back_to_back();
    test_full_range();

    in_chan.valid <= 1'b0;
    while (lcm_pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (error_count == 0 && lcm_pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### lcm_int64_euclid_top.f
+incdir+rtl
rtl/lcm_pkg.sv
rtl/lcm_if.sv
rtl/lcm_div.sv
rtl/lcm_mul.sv
rtl/lcm_int64_euclid_top.sv
rtl/lcm_checker.sv
tb/tb_lcm_int64_euclid_top.sv
